// File: hw/rtl/tcpu_pkg.sv
// package: shared constants and types for the toy cpu core
package tcpu_pkg;
    localparam int unsigned MEM_BYTES_DEF = 1024;
    localparam int unsigned DATA_W = 16;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_MOVE = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_SUB  = 8'd3;
    localparam logic [7:0] OP_MUL  = 8'd4;
    localparam logic [7:0] OP_DIV  = 8'd5;
    localparam logic [7:0] OP_AND  = 8'd6;
    localparam logic [7:0] OP_OR   = 8'd7;
    localparam logic [7:0] OP_NOT  = 8'd8;
    localparam logic [7:0] OP_CMP  = 8'd9;
    localparam logic [7:0] OP_JMP  = 8'd10;
    localparam logic [7:0] OP_IN   = 8'd11;
    localparam logic [7:0] OP_OUT  = 8'd12;

    localparam logic [1:0] FLAG_EQ = 2'b00;
    localparam logic [1:0] FLAG_GT = 2'b01;
    localparam logic [1:0] FLAG_LT = 2'b11;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  load_addr;
        logic [7:0]  load_byte;
        logic signed [15:0] in_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] next_ip;
        logic signed [1:0] flag_value;
        logic        out_valid;
        logic signed [15:0] out_value;
    } t_out_item;
endpackage

// File: hw/rtl/tcpu_if.sv
// interfaces: valid/ready channels for input and result items
interface tcpu_in_if;
    logic                valid;
    logic                ready;
    tcpu_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcpu_out_if;
    logic                valid;
    logic                ready;
    tcpu_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/toy_cpu_core_step.sv
// top level: sequenced toy cpu core around one byte memory
//
//  channel   | dir | payload
//  i_in      | in  | cmd, load_addr, load_byte, in_value
//  o_out     | out | status, next_ip, flag_value, out_valid, out_value
//
// a byte load is written to memory when it is taken and goes straight to its result;
// an instruction runs four byte fetches, two operand byte reads, execute and result, with
// two byte writes for a store and 16 restoring steps and a write back for a divide.
// a taken result frees the input in the next cycle.
// synchronous active low reset clears registers, ip, flag and halt; the memory,
// whose size is a power of two, is not cleared. a waiting result holds the core.
module toy_cpu_core_step #(
    parameter int unsigned MEM_BYTES = tcpu_pkg::MEM_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tcpu_in_if.sink    i_in,
    tcpu_out_if.source o_out
);
    localparam int unsigned AW = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_OPA, S_OPB, S_EXEC, S_DIV, S_WR_HI, S_WR_LO, S_DONE
    } t_state;

    t_state r_state;
    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;
    logic [15:0] r_regs [8];
    logic [15:0] r_ip;
    logic [1:0]  r_flag;
    logic        r_halted;
    tcpu_pkg::t_in_item  r_in;
    tcpu_pkg::t_out_item r_out;
    logic        r_out_valid;
    logic [2:0]  r_cnt;
    logic [7:0]  r_op;
    logic [3:0]  r_r1, r_r2;
    logic [15:0] r_imm, r_bv, r_wval, r_waddr;
    // divider
    logic [4:0]  r_dcnt;
    logic [15:0] r_quo, r_rem, r_dvs;
    logic        r_qneg;

    // memory port
    logic          n_we;
    logic [AW-1:0] n_addr;
    logic [7:0]    n_wdata;

    if ((MEM_BYTES & (MEM_BYTES - 1)) != 0) begin : g_mem_size_check
        $error("MEM_BYTES must be a power of two");
    end

    function automatic logic [15:0] reg_rd(input logic [15:0] regs [8], input logic [3:0] r);
        logic [3:0] k;
        k = r - 4'd1;
        if (r >= 4'd1 && r <= 4'd8) return regs[k[2:0]];
        return 16'd0;
    endfunction

    function automatic logic [AW-1:0] maddr(input logic [15:0] a);
        return AW'(32'(a) % MEM_BYTES);
    endfunction

    // write one general register, numbers outside one to eight are dropped
    task automatic wr_reg(input logic [3:0] r, input logic [15:0] v);
        logic [3:0] k;
        k = r - 4'd1;
        if (r >= 4'd1 && r <= 4'd8) r_regs[k[2:0]] <= v;
    endtask

    logic [15:0] w_a, w_r2v, w_ipb, w_addr_b;
    logic        w_need_b;
    logic        w_take;
    t_state      w_exec_state;
    assign w_a = reg_rd(r_regs, r_r1);
    assign w_r2v = reg_rd(r_regs, r_r2);
    // fetch address runs one byte behind the counter
    assign w_ipb = r_ip + 16'(r_cnt) - 16'd1;
    assign w_addr_b = w_r2v + 16'(r_cnt);
    assign w_need_b = (r_r2 != 4'd0);
    assign w_take = (r_r2 == 4'd0) || (r_r2 == 4'd1 && r_flag == tcpu_pkg::FLAG_EQ) ||
                    (r_r2 == 4'd2 && r_flag == tcpu_pkg::FLAG_GT) ||
                    (r_r2 == 4'd3 && r_flag == tcpu_pkg::FLAG_LT);

    always_comb begin
        if ((r_op == tcpu_pkg::OP_MOVE && r_r2 != 4'd0 && r_r2 <= 4'd4) ||
            (r_op == tcpu_pkg::OP_NOT && r_r2 != 4'd0)) begin
            w_exec_state = S_WR_HI;
        end else if (r_op == tcpu_pkg::OP_DIV && r_bv != 16'd0) begin
            w_exec_state = S_DIV;
        end else begin
            w_exec_state = S_DONE;
        end
    end

    always_comb begin
        n_we = 1'b0;
        n_addr = maddr(w_ipb);
        n_wdata = r_in.load_byte;
        case (r_state)
            S_IDLE: begin
                n_we = i_in.valid && i_in.ready && (i_in.data.cmd == tcpu_pkg::CMD_LOAD);
                n_addr = maddr({6'd0, i_in.data.load_addr});
                n_wdata = i_in.data.load_byte;
            end
            S_FETCH: n_addr = maddr(w_ipb);
            S_OPA, S_OPB: n_addr = maddr(w_addr_b);
            S_WR_HI: begin
                n_we = 1'b1; n_addr = maddr(r_waddr); n_wdata = r_wval[15:8];
            end
            S_WR_LO: begin
                n_we = 1'b1; n_addr = maddr(r_waddr + 16'd1); n_wdata = r_wval[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_addr] <= n_wdata;
        r_rdata <= r_mem[n_addr];
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;

    // divider operand magnitudes
    logic signed [15:0] w_sa, w_sb;
    logic [15:0] w_ma, w_mb;
    logic [16:0] w_trial;
    assign w_sa = signed'(w_a);
    assign w_sb = signed'(r_bv);
    assign w_ma = w_sa[15] ? 16'(-w_a) : w_a;
    assign w_mb = w_sb[15] ? 16'(-r_bv) : r_bv;
    assign w_trial = {r_rem[14:0], r_quo[15]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ip <= '0;
            r_flag <= tcpu_pkg::FLAG_EQ;
            r_halted <= 1'b0;
            for (int i = 0; i < 8; i++) r_regs[i] <= '0;
        end else begin
            if (o_out.valid && o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_in <= i_in.data;
                        r_out.out_valid <= 1'b0;
                        r_out.out_value <= '0;
                        r_cnt <= 3'd1;
                        if (i_in.data.cmd == tcpu_pkg::CMD_LOAD) begin
                            r_out.status <= tcpu_pkg::ST_DONE;
                            r_state <= S_DONE;
                        end else if (r_halted) begin
                            r_out.status <= tcpu_pkg::ST_REFUSED;
                            r_state <= S_DONE;
                        end else begin
                            r_out.status <= tcpu_pkg::ST_DONE;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    // read data is registered and arrives the cycle after its address
                    case (r_cnt)
                        3'd2: r_op <= r_rdata;
                        3'd3: begin r_r1 <= r_rdata[7:4]; r_r2 <= r_rdata[3:0]; end
                        3'd4: r_imm[15:8] <= r_rdata;
                        default: ;
                    endcase
                    if (r_cnt == 3'd4) begin
                        r_state <= S_OPA;
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_OPA: begin
                    r_imm[7:0] <= r_rdata;
                    r_cnt <= 3'd1;
                    r_state <= S_OPB;
                end
                S_OPB: begin
                    if (r_cnt == 3'd1) begin
                        r_bv[15:8] <= r_rdata;
                        r_cnt <= 3'd2;
                    end else begin
                        if (w_need_b) r_bv[7:0] <= r_rdata;
                        else r_bv <= r_imm;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_ip <= (r_op == tcpu_pkg::OP_JMP && w_take) ? r_ip + r_imm
                                                                 : r_ip + 16'd4;
                    r_state <= w_exec_state;
                    case (r_op)
                        tcpu_pkg::OP_HALT: begin
                            r_halted <= 1'b1;
                            r_out.status <= tcpu_pkg::ST_HALTED;
                        end
                        tcpu_pkg::OP_MOVE: begin
                            if (r_r2 == 4'd0) wr_reg(r_r1, r_imm);
                            else if (r_r2 <= 4'd4) begin
                                r_waddr <= w_a; r_wval <= w_r2v;
                            end else wr_reg(r_r1, r_bv);
                        end
                        tcpu_pkg::OP_ADD: wr_reg(r_r1, w_a + r_bv);
                        tcpu_pkg::OP_SUB: wr_reg(r_r1, w_a - r_bv);
                        tcpu_pkg::OP_MUL: wr_reg(r_r1, 16'(w_a * r_bv));
                        tcpu_pkg::OP_DIV: begin
                            if (r_bv == 16'd0) r_out.status <= tcpu_pkg::ST_DIVZERO;
                            else begin
                                r_quo <= w_ma; r_rem <= '0; r_dvs <= w_mb;
                                r_qneg <= w_sa[15] ^ w_sb[15];
                                r_dcnt <= 5'd16;
                            end
                        end
                        tcpu_pkg::OP_AND:
                            wr_reg(r_r1, {15'd0, (w_a != 16'd0) && (r_bv != 16'd0)});
                        tcpu_pkg::OP_OR:
                            wr_reg(r_r1, {15'd0, (w_a != 16'd0) || (r_bv != 16'd0)});
                        tcpu_pkg::OP_NOT: begin
                            if (r_r2 == 4'd0) wr_reg(r_r1, {15'd0, w_a == 16'd0});
                            else begin
                                r_waddr <= w_r2v; r_wval <= {15'd0, r_bv == 16'd0};
                            end
                        end
                        tcpu_pkg::OP_CMP:
                            r_flag <= (w_sa > w_sb) ? tcpu_pkg::FLAG_GT :
                                      (w_sa == w_sb) ? tcpu_pkg::FLAG_EQ : tcpu_pkg::FLAG_LT;
                        tcpu_pkg::OP_IN: wr_reg(r_r1, r_in.in_value);
                        tcpu_pkg::OP_OUT: begin
                            r_out.out_valid <= 1'b1;
                            r_out.out_value <= w_a;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (r_dcnt != 5'd0) begin
                        r_dcnt <= r_dcnt - 5'd1;
                        if (!w_trial[16]) begin
                            r_rem <= w_trial[15:0];
                            r_quo <= {r_quo[14:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[14:0], r_quo[15]};
                            r_quo <= {r_quo[14:0], 1'b0};
                        end
                    end else begin
                        wr_reg(r_r1, r_qneg ? 16'(-r_quo) : r_quo);
                        r_state <= S_DONE;
                    end
                end
                S_WR_HI: r_state <= S_WR_LO;
                S_WR_LO: r_state <= S_DONE;
                S_DONE: begin
                    r_out.next_ip <= r_ip;
                    r_out.flag_value <= r_flag;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/tcpu_checker.sv
// checker: port level properties of the toy cpu core, bound to the top level
module tcpu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_status,
    input logic out_flag_out_valid,
    input logic [15:0] out_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_one_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_flag_out_valid |-> out_value == 16'd0)
        else $error("out_value not zero");
    a_status_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_flag_out_valid |-> out_status == tcpu_pkg::ST_DONE)
        else $error("output step with bad status");
endmodule

bind toy_cpu_core_step tcpu_checker u_tcpu_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .in_valid(i_in.valid),
    .in_ready(i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_status(o_out.data.status),
    .out_flag_out_valid(o_out.data.out_valid),
    .out_value(o_out.data.out_value)
);
